// ----- design/vec3_refract_macros.svh -----
`ifndef VEC3_REFRACT_MACROS_SVH
`define VEC3_REFRACT_MACROS_SVH

// same-cycle implication
`define VR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/vr_pkg.sv -----
`default_nettype none

package vr_pkg;

   localparam int WORD_BITS_DEF = 24;
   localparam int FRAC_BITS_DEF = 16;
   localparam int INNER_BITS    = 32;

   localparam logic signed [63:0] INNER_MAX = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] INNER_MIN = -64'sh0000_0000_8000_0000;

   function automatic logic signed [INNER_BITS-1:0] clamp_inner(input logic signed [63:0] x);
      logic signed [INNER_BITS-1:0] res;
      if (x > INNER_MAX) begin
         res = INNER_BITS'(INNER_MAX);
      end else if (x < INNER_MIN) begin
         res = INNER_BITS'(INNER_MIN);
      end else begin
         res = INNER_BITS'(x);
      end
      return res;
   endfunction

   // exact product, floored by frac bits
   function automatic logic signed [63:0] qmul(input logic signed [INNER_BITS-1:0] a,
                                               input logic signed [INNER_BITS-1:0] b,
                                               input int unsigned frac);
      logic signed [63:0] p;
      p = 64'(a) * 64'(b);
      return p >>> frac;
   endfunction

endpackage

`default_nettype wire

// ----- design/vr_if.sv -----
`default_nettype none

interface vr_req_if #(parameter int W = vr_pkg::WORD_BITS_DEF);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] incident_x;
   logic signed [W-1:0] incident_y;
   logic signed [W-1:0] incident_z;
   logic signed [W-1:0] normal_x;
   logic signed [W-1:0] normal_y;
   logic signed [W-1:0] normal_z;
   logic signed [W-1:0] index_ratio;

   modport source (output valid, incident_x, incident_y, incident_z,
                   normal_x, normal_y, normal_z, index_ratio, input ready);
   modport sink   (input valid, incident_x, incident_y, incident_z,
                   normal_x, normal_y, normal_z, index_ratio, output ready);
endinterface

interface vr_rsp_if #(parameter int W = vr_pkg::WORD_BITS_DEF);
   logic                valid;
   logic                ready;
   logic signed [W-1:0] refracted_x;
   logic signed [W-1:0] refracted_y;
   logic signed [W-1:0] refracted_z;
   logic                total_reflection;
   logic                saturated;

   modport source (output valid, refracted_x, refracted_y, refracted_z,
                   total_reflection, saturated, input ready);
   modport sink   (input valid, refracted_x, refracted_y, refracted_z,
                   total_reflection, saturated, output ready);
endinterface

`default_nettype wire

// ----- design/vec3_refract.sv -----
// channel | dir | word contents
// req     | in  | incident_x/y/z, normal_x/y/z, index_ratio
// rsp     | out | refracted_x/y/z, total_reflection, saturated
//
// One word per cycle sustained while rsp is ready; the floor square root
// is computed with one root bit per stage.
// Reset clears only the stage valid bits.
// Each stage advances when the next one is empty or advancing, so bubbles
// collapse and a stalled rsp holds its word while earlier stages still fill.
`include "vec3_refract_macros.svh"
`default_nettype none

module vec3_refract #(
   parameter int WORD_BITS = vr_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = vr_pkg::FRAC_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   vr_req_if.sink    req,
   vr_rsp_if.source  rsp
);

   localparam int W  = WORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int IB = vr_pkg::INNER_BITS;
   localparam int EW = IB + W - F;
   localparam int XB = IB - 1 + F;
   localparam int RB = (XB + 1) / 2;
   localparam int SQ = 6;
   localparam int SS = SQ + RB;
   localparam int N  = SS + 3;

   localparam logic signed [63:0] ONE    = 64'sd1 <<< F;
   localparam logic signed [EW:0] WMAX_E = (EW+1)'((64'sd1 <<< (W - 1)) - 64'sd1);
   localparam logic signed [EW:0] WMIN_E = -WMAX_E - (EW+1)'(1);

   typedef struct packed {
      logic signed [W-1:0]           ix, iy, iz, nx, ny, nz, r;
      logic signed [2:0][EW-1:0]     ri;
      logic signed [2:0][EW-1:0]     e;
      logic signed [EW-1:0]          rdw;
      logic signed [IB-1:0]          d, rr, t;
      logic [XB-1:0]                 rem;
      logic [RB-1:0]                 root;
      logic                          tir;
      logic                          sat;
      logic signed [2:0][W-1:0]      o;
   } pipe_type;

   pipe_type pipe_ff [N];
   logic     v_ff    [N];
   logic     en      [N];

   assign en[N-1]   = !v_ff[N-1] || rsp.ready;
   assign req.ready = en[0];

   for (genvar k = 0; k < N; k++) begin : g_stage
      pipe_type pipe_in;
      logic     v_in;

      if (k < N - 1) begin : g_en
         assign en[k] = !v_ff[k] || en[k+1];
      end

      if (k == 0) begin : g_s0
         assign v_in = req.valid;
         always_comb begin
            pipe_in      = '0;
            pipe_in.ix   = req.incident_x;
            pipe_in.iy   = req.incident_y;
            pipe_in.iz   = req.incident_z;
            pipe_in.nx   = req.normal_x;
            pipe_in.ny   = req.normal_y;
            pipe_in.nz   = req.normal_z;
            pipe_in.r    = req.index_ratio;
            pipe_in.e[0] = EW'(vr_pkg::qmul(IB'(req.normal_x), IB'(req.incident_x), F));
            pipe_in.e[1] = EW'(vr_pkg::qmul(IB'(req.normal_y), IB'(req.incident_y), F));
            pipe_in.e[2] = EW'(vr_pkg::qmul(IB'(req.normal_z), IB'(req.incident_z), F));
            pipe_in.ri[0] = EW'(vr_pkg::qmul(IB'(req.index_ratio), IB'(req.incident_x), F));
            pipe_in.ri[1] = EW'(vr_pkg::qmul(IB'(req.index_ratio), IB'(req.incident_y), F));
            pipe_in.ri[2] = EW'(vr_pkg::qmul(IB'(req.index_ratio), IB'(req.incident_z), F));
            pipe_in.rr   = vr_pkg::clamp_inner(
                              vr_pkg::qmul(IB'(req.index_ratio), IB'(req.index_ratio), F));
         end
      end else begin : g_sn
         assign v_in = v_ff[k-1];
         if (k == 1) begin : g_dot
            always_comb begin
               pipe_in   = pipe_ff[k-1];
               pipe_in.d = vr_pkg::clamp_inner(64'($signed(pipe_ff[k-1].e[0])) +
                                               64'($signed(pipe_ff[k-1].e[1])) +
                                               64'($signed(pipe_ff[k-1].e[2])));
            end
         end else if (k == 2) begin : g_dd
            always_comb begin
               pipe_in     = pipe_ff[k-1];
               pipe_in.t   = vr_pkg::clamp_inner(
                                vr_pkg::qmul(pipe_ff[k-1].d, pipe_ff[k-1].d, F));
               pipe_in.rdw = EW'(vr_pkg::qmul(IB'(pipe_ff[k-1].r), pipe_ff[k-1].d, F));
            end
         end else if (k == 3) begin : g_omd
            always_comb begin
               pipe_in   = pipe_ff[k-1];
               pipe_in.t = vr_pkg::clamp_inner(ONE - 64'(pipe_ff[k-1].t));
            end
         end else if (k == 4) begin : g_rrt
            always_comb begin
               pipe_in   = pipe_ff[k-1];
               pipe_in.t = vr_pkg::clamp_inner(
                              vr_pkg::qmul(pipe_ff[k-1].rr, pipe_ff[k-1].t, F));
            end
         end else if (k == 5) begin : g_k
            logic signed [IB-1:0] kv;
            always_comb begin
               kv           = vr_pkg::clamp_inner(ONE - 64'(pipe_ff[k-1].t));
               pipe_in      = pipe_ff[k-1];
               pipe_in.tir  = kv[IB-1];
               pipe_in.root = '0;
               pipe_in.rem  = kv[IB-1] ? '0 : XB'(64'(kv) << F);
            end
         end else if (k < SS) begin : g_sqrt
            localparam int B = RB - 1 - (k - SQ);
            logic [XB:0] trial;
            always_comb begin
               pipe_in = pipe_ff[k-1];
               trial   = ((XB+1)'(pipe_ff[k-1].root) << (B + 1)) + ((XB+1)'(1) << (2 * B));
               if ({1'b0, pipe_ff[k-1].rem} >= trial) begin
                  pipe_in.rem     = pipe_ff[k-1].rem - XB'(trial);
                  pipe_in.root[B] = 1'b1;
               end
            end
         end else if (k == SS) begin : g_s
            always_comb begin
               pipe_in   = pipe_ff[k-1];
               pipe_in.t = vr_pkg::clamp_inner(64'(pipe_ff[k-1].rdw) +
                                               64'(signed'({1'b0, pipe_ff[k-1].root})));
            end
         end else if (k == SS + 1) begin : g_sn
            always_comb begin
               pipe_in      = pipe_ff[k-1];
               pipe_in.e[0] = EW'(vr_pkg::qmul(pipe_ff[k-1].t, IB'(pipe_ff[k-1].nx), F));
               pipe_in.e[1] = EW'(vr_pkg::qmul(pipe_ff[k-1].t, IB'(pipe_ff[k-1].ny), F));
               pipe_in.e[2] = EW'(vr_pkg::qmul(pipe_ff[k-1].t, IB'(pipe_ff[k-1].nz), F));
            end
         end else begin : g_out
            logic signed [EW:0] dv [3];
            always_comb begin
               pipe_in     = pipe_ff[k-1];
               pipe_in.sat = 1'b0;
               for (int j = 0; j < 3; j++) begin
                  dv[j] = (EW+1)'($signed(pipe_ff[k-1].ri[j])) -
                          (EW+1)'($signed(pipe_ff[k-1].e[j]));
                  if (dv[j] > WMAX_E) begin
                     pipe_in.o[j] = W'(WMAX_E);
                     pipe_in.sat  = 1'b1;
                  end else if (dv[j] < WMIN_E) begin
                     pipe_in.o[j] = W'(WMIN_E);
                     pipe_in.sat  = 1'b1;
                  end else begin
                     pipe_in.o[j] = W'(dv[j]);
                  end
               end
               if (pipe_ff[k-1].tir) begin
                  pipe_in.o   = '0;
                  pipe_in.sat = 1'b0;
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= v_in;
         end
         if (en[k] && v_in) begin
            pipe_ff[k] <= pipe_in;
         end
      end
   end

   assign rsp.valid            = v_ff[N-1];
   assign rsp.refracted_x      = pipe_ff[N-1].o[0];
   assign rsp.refracted_y      = pipe_ff[N-1].o[1];
   assign rsp.refracted_z      = pipe_ff[N-1].o[2];
   assign rsp.total_reflection = pipe_ff[N-1].tir;
   assign rsp.saturated        = pipe_ff[N-1].sat;

   `VR_ASSERT_NOW(a_tir_zero, clock, reset, (rsp.valid && rsp.total_reflection), ((rsp.refracted_x == '0) && (rsp.refracted_y == '0) && (rsp.refracted_z == '0) && !rsp.saturated), "total reflection word not zero")
   `VR_ASSERT_NOW(a_stall_src, clock, reset, (!req.ready), (rsp.valid && !rsp.ready), "req stalled without rsp backpressure")
   `VR_ASSERT_NEXT(a_out_hold, clock, reset, (rsp.valid && !rsp.ready && !reset), (rsp.valid), "rsp word dropped while stalled")

endmodule

`default_nettype wire
